[rtl/bqcd_pkg.sv]
// Shared types, constants and the arctangent table for the biquad coefficient designer.
`default_nettype none

package bqcd_pkg;

   // Filter type carried with each design request
   typedef enum logic [1:0] {
      CMD_LOWPASS  = 2'd0,
      CMD_HIGHPASS = 2'd1,
      CMD_BANDPASS = 2'd2,
      CMD_NOTCH    = 2'd3
   } cmd_type;

   // Width of the CORDIC datapath (Q30 with headroom and sign)
   localparam int ANG_W = 34;

   // Low 32 bits of 2*pi in Q30; bit 32 of the constant is set as well
   localparam logic [31:0] TWO_PI_LO   = 32'h921FB544;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [41:0] ONE_Q30 = 42'sd1073741824;

   // Sideband carried through the w0 divider
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] quality;
      logic        invalid;
   } w0_side_type;

   // Sideband carried through the CORDIC
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] quality;
      logic        invalid;
      logic        fold;
   } cordic_side_type;

   // Sideband carried through the alpha divider
   typedef struct packed {
      cmd_type                 cmd;
      logic                    invalid;
      logic signed [ANG_W-1:0] cosv;
   } alpha_side_type;

   // Sideband carried through each coefficient divider
   typedef struct packed {
      cmd_type cmd;
      logic    invalid;
      logic    neg;
   } coef_side_type;

   // floor(atan(2^-idx) * 2^30)
   function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         0: val = 34'sh03243F6A8;
         1: val = 34'sh01DAC6705;
         2: val = 34'sh00FADBAFC;
         3: val = 34'sh007F56EA6;
         4: val = 34'sh003FEAB76;
         5: val = 34'sh001FFD55B;
         6: val = 34'sh000FFFAAA;
         7: val = 34'sh0007FFF55;
         8: val = 34'sh0003FFFEA;
         9: val = 34'sh0001FFFFD;
         default: begin
            if (idx < 30) begin
               val = (ANG_W'(1) << (30 - idx)) - ANG_W'(1);
            end else begin
               val = '0;
            end
         end
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[rtl/bqcd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module bqcd_div #(
   parameter int NUM_W  = 57,
   parameter int DEN_W  = 24,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  low_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic              cur_valid;
      logic [DEN_W-1:0]  cur_rem;
      logic [QUO_W-1:0]  cur_low;
      logic [DEN_W-1:0]  cur_den;
      logic [SIDE_W-1:0] cur_side;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;

      // Take the dividend head as the first partial remainder
      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = DEN_W'(in_num >> QUO_W);
         assign cur_low   = in_num[QUO_W-1:0];
         assign cur_den   = in_den;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_low   = low_ff[k-1];
         assign cur_den   = den_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      // Bring down one bit, trial-subtract the divisor
      assign trial = {cur_rem, cur_low[QUO_W-1]};
      assign ge    = trial >= {1'b0, cur_den};
      assign diff  = trial - {1'b0, cur_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      // Shift the quotient bit in where the dividend bit left
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[k]  <= {cur_low[QUO_W-2:0], ge};
            den_ff[k]  <= cur_den;
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = low_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

[rtl/bqcd_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
`default_nettype none

module bqcd_cordic import bqcd_pkg::*; #(
   parameter int ITER   = 24,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_angle,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_cos,
   output logic signed [ANG_W-1:0] out_sin,
   output logic [SIDE_W-1:0]       out_side
);

   logic                    valid_ff [ITER];
   logic signed [ANG_W-1:0] x_ff     [ITER];
   logic signed [ANG_W-1:0] y_ff     [ITER];
   logic signed [ANG_W-1:0] z_ff     [ITER];
   logic [SIDE_W-1:0]       side_ff  [ITER];

   for (genvar k = 0; k < ITER; k++) begin : g_rot
      localparam logic signed [ANG_W-1:0] ATAN_K = atan_q30(k);
      logic                    cur_valid;
      logic signed [ANG_W-1:0] cur_x;
      logic signed [ANG_W-1:0] cur_y;
      logic signed [ANG_W-1:0] cur_z;
      logic [SIDE_W-1:0]       cur_side;
      logic signed [ANG_W-1:0] dx;
      logic signed [ANG_W-1:0] dy;

      // Start from the gain-compensated unit vector
      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_x     = GAIN_Q30;
         assign cur_y     = '0;
         assign cur_z     = in_angle;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_x     = x_ff[k-1];
         assign cur_y     = y_ff[k-1];
         assign cur_z     = z_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      assign dx = cur_y >>> k;
      assign dy = cur_x >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      // Rotate toward zero residual angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (!cur_z[ANG_W-1]) begin
               x_ff[k] <= cur_x - dx;
               y_ff[k] <= cur_y + dy;
               z_ff[k] <= cur_z - ATAN_K;
            end else begin
               x_ff[k] <= cur_x + dx;
               y_ff[k] <= cur_y - dy;
               z_ff[k] <= cur_z + ATAN_K;
            end
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[ITER-1];
   assign out_cos   = x_ff[ITER-1];
   assign out_sin   = y_ff[ITER-1];
   assign out_side  = side_ff[ITER-1];

endmodule

`default_nettype wire

[rtl/biquad_coefficient_designer.sv]
// The pipeline is built from the bit-per-stage w0, alpha and coefficient dividers and the
// stage-per-iteration CORDIC, with registered stages between them.
// Throughput: one design per cycle; the whole pipeline holds while the result is stalled.
// Reset (synchronous, active high) empties the pipeline and sets the sample rate to 48000.
// Top level: RBJ cookbook biquad coefficient designer.
`default_nettype none

module biquad_coefficient_designer import bqcd_pkg::*; #(
   parameter int COEF_FRAC_BITS    = 29,
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [23:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [23:0]        req_cutoff_hz,
   input  logic [15:0]        req_quality,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_coef_b0,
   output logic signed [31:0] rsp_coef_b1,
   output logic signed [31:0] rsp_coef_b2,
   output logic signed [31:0] rsp_coef_a1,
   output logic signed [31:0] rsp_coef_a2,
   output logic               rsp_design_status
);

   localparam int QW     = COEF_FRAC_BITS + 12;
   localparam int MAG_W  = 40;
   localparam int CDEN_W = 41;
   localparam int CNUM_W = MAG_W + COEF_FRAC_BITS + 1;
   localparam int RW     = QW + 8;
   localparam int LANES  = 4;

   logic en;
   logic [23:0] sample_rate_ff;

   // Sample rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= 24'd48000;
      end else if (csr_wr_en) begin
         sample_rate_ff <= csr_wr_data;
      end
   end

   // Advance everything unless the finished result is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- Stage 0: capture and check the request
   logic        s0_valid_ff;
   cmd_type     s0_cmd_ff;
   logic [23:0] s0_fc_ff;
   logic [23:0] s0_fs_ff;
   logic [15:0] s0_q_ff;
   logic        s0_invalid_ff;
   logic        s0_invalid_in;

   assign s0_invalid_in = (sample_rate_ff == 24'd0) || (req_cutoff_hz == 24'd0) ||
                          (req_quality == 16'd0) ||
                          ({req_cutoff_hz, 1'b0} >= {1'b0, sample_rate_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_cmd_ff     <= cmd_type'(req_cmd);
         s0_fc_ff      <= req_cutoff_hz;
         s0_fs_ff      <= sample_rate_ff;
         s0_q_ff       <= req_quality;
         s0_invalid_ff <= s0_invalid_in;
      end
   end

   // ---------------- Stage 1: cutoff times 2*pi
   logic        s1_valid_ff;
   logic [56:0] s1_prod_ff;
   logic [23:0] s1_fs_ff;
   w0_side_type s1_side_ff;
   logic [55:0] mult_lo;

   assign mult_lo = 56'(s0_fc_ff) * 56'(TWO_PI_LO);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff         <= 57'(mult_lo) + {1'b0, s0_fc_ff, 32'd0};
         s1_fs_ff           <= s0_fs_ff;
         s1_side_ff.cmd     <= s0_cmd_ff;
         s1_side_ff.quality <= s0_q_ff;
         s1_side_ff.invalid <= s0_invalid_ff;
      end
   end

   // ---------------- w0 = product / sample rate
   logic        w0_valid;
   logic [31:0] w0_quo;
   w0_side_type w0_side;

   bqcd_div #(
      .NUM_W (57),
      .DEN_W (24),
      .QUO_W (32),
      .SIDE_W($bits(w0_side_type))
   ) u_w0_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s1_valid_ff),
      .in_num   (s1_prod_ff),
      .in_den   (s1_fs_ff),
      .in_side  (s1_side_ff),
      .out_valid(w0_valid),
      .out_quo  (w0_quo),
      .out_side (w0_side)
   );

   // ---------------- Stage 2: fold into the first quadrant
   logic                    s2_valid_ff;
   logic signed [ANG_W-1:0] s2_angle_ff;
   cordic_side_type         s2_side_ff;
   logic                    fold_in;
   logic [31:0]             angle_in;

   assign fold_in  = w0_quo > HALF_PI_Q30;
   assign angle_in = fold_in ? (PI_Q30 - w0_quo) : w0_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= w0_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_angle_ff        <= $signed({2'b00, angle_in});
         s2_side_ff.cmd     <= w0_side.cmd;
         s2_side_ff.quality <= w0_side.quality;
         s2_side_ff.invalid <= w0_side.invalid;
         s2_side_ff.fold    <= fold_in;
      end
   end

   // ---------------- cos and sin of the folded angle
   logic                    cor_valid;
   logic signed [ANG_W-1:0] cor_x;
   logic signed [ANG_W-1:0] cor_y;
   cordic_side_type         cor_side;

   bqcd_cordic #(
      .ITER  (CORDIC_ITERATIONS),
      .SIDE_W($bits(cordic_side_type))
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s2_valid_ff),
      .in_angle (s2_angle_ff),
      .in_side  (s2_side_ff),
      .out_valid(cor_valid),
      .out_cos  (cor_x),
      .out_sin  (cor_y),
      .out_side (cor_side)
   );

   // ---------------- Stage 3: unfold cosine, clamp sine
   logic           s3_valid_ff;
   logic [31:0]    s3_sin_ff;
   logic [15:0]    s3_q_ff;
   alpha_side_type s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sin_ff          <= cor_y[ANG_W-1] ? 32'd0 : cor_y[31:0];
         s3_q_ff            <= cor_side.quality;
         s3_side_ff.cmd     <= cor_side.cmd;
         s3_side_ff.invalid <= cor_side.invalid;
         s3_side_ff.cosv    <= cor_side.fold ? -cor_x : cor_x;
      end
   end

   // ---------------- alpha = sin * 128 / Q
   logic           al_valid;
   logic [37:0]    al_quo;
   alpha_side_type al_side;

   bqcd_div #(
      .NUM_W (39),
      .DEN_W (16),
      .QUO_W (38),
      .SIDE_W($bits(alpha_side_type))
   ) u_alpha_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .in_num   ({s3_sin_ff, 7'd0}),
      .in_den   (s3_q_ff),
      .in_side  (s3_side_ff),
      .out_valid(al_valid),
      .out_quo  (al_quo),
      .out_side (al_side)
   );

   // ---------------- Stage 4: numerators and denominators per coefficient
   // lanes: b0, b1, a1, a2 (b2 follows from b0)
   logic signed [41:0] cos_w;
   logic signed [41:0] alpha_w;
   logic signed [41:0] a0_w;
   logic signed [41:0] num_w [LANES];
   logic [CDEN_W-1:0]  den_w [LANES];
   logic [CDEN_W-1:0]  a0_d;
   logic [CDEN_W-1:0]  a0x2_d;

   logic              s4_valid_ff;
   logic [MAG_W-1:0]  s4_mag_ff [LANES];
   logic [CDEN_W-1:0] s4_den_ff [LANES];
   logic              s4_neg_ff [LANES];
   cmd_type           s4_cmd_ff;
   logic              s4_invalid_ff;

   assign cos_w   = {{(42-ANG_W){al_side.cosv[ANG_W-1]}}, al_side.cosv};
   assign alpha_w = {4'd0, al_quo};
   assign a0_w    = ONE_Q30 + alpha_w;
   assign a0_d    = CDEN_W'(a0_w);
   assign a0x2_d  = CDEN_W'(a0_w <<< 1);

   // Select the cookbook numerators for the filter type
   always_comb begin
      num_w[2] = -(cos_w <<< 1);
      num_w[3] = ONE_Q30 - alpha_w;
      den_w[1] = a0_d;
      den_w[2] = a0_d;
      den_w[3] = a0_d;
      unique case (al_side.cmd)
         CMD_LOWPASS: begin
            num_w[0] = ONE_Q30 - cos_w;
            den_w[0] = a0x2_d;
            num_w[1] = ONE_Q30 - cos_w;
         end
         CMD_HIGHPASS: begin
            num_w[0] = ONE_Q30 + cos_w;
            den_w[0] = a0x2_d;
            num_w[1] = -(ONE_Q30 + cos_w);
         end
         CMD_BANDPASS: begin
            num_w[0] = alpha_w;
            den_w[0] = a0_d;
            num_w[1] = '0;
         end
         CMD_NOTCH: begin
            num_w[0] = ONE_Q30;
            den_w[0] = a0_d;
            num_w[1] = -(cos_w <<< 1);
         end
         default: begin
            num_w[0] = '0;
            den_w[0] = a0_d;
            num_w[1] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= al_valid;
      end
   end

   // Split each numerator into sign and magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) begin
            s4_neg_ff[j] <= num_w[j][41];
            s4_mag_ff[j] <= num_w[j][41] ? MAG_W'(-num_w[j]) : MAG_W'(num_w[j]);
            s4_den_ff[j] <= den_w[j];
         end
         s4_cmd_ff     <= al_side.cmd;
         s4_invalid_ff <= al_side.invalid;
      end
   end

   // ---------------- Coefficient dividers with one guard bit
   logic          cd_valid [LANES];
   logic [QW-1:0] cd_quo   [LANES];
   coef_side_type cd_side  [LANES];
   coef_side_type cd_side_in [LANES];

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      assign cd_side_in[j].cmd     = s4_cmd_ff;
      assign cd_side_in[j].invalid = s4_invalid_ff;
      assign cd_side_in[j].neg     = s4_neg_ff[j];

      bqcd_div #(
         .NUM_W (CNUM_W),
         .DEN_W (CDEN_W),
         .QUO_W (QW),
         .SIDE_W($bits(coef_side_type))
      ) u_coef_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (s4_valid_ff),
         .in_num   ({s4_mag_ff[j], {(COEF_FRAC_BITS + 1){1'b0}}}),
         .in_den   (s4_den_ff[j]),
         .in_side  (cd_side_in[j]),
         .out_valid(cd_valid[j]),
         .out_quo  (cd_quo[j]),
         .out_side (cd_side[j])
      );
   end

   // ---------------- Stage 5: round half away from zero, saturate, register result
   logic [RW-1:0]      rnd [LANES];
   logic signed [31:0] res [LANES];
   logic               cd_valid_all;

   assign cd_valid_all = cd_valid[0] && cd_valid[1] && cd_valid[2] && cd_valid[3];

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         rnd[j] = (RW'(cd_quo[j]) + RW'(1)) >> 1;
         if (!cd_side[j].neg) begin
            res[j] = (rnd[j] > RW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(rnd[j][31:0]);
         end else begin
            res[j] = (rnd[j] > RW'(33'h080000000)) ? 32'sh80000000 :
                     $signed(32'd0 - rnd[j][31:0]);
         end
      end
   end

   logic               rsp_valid_ff;
   logic signed [31:0] b0_ff;
   logic signed [31:0] b1_ff;
   logic signed [31:0] b2_ff;
   logic signed [31:0] a1_ff;
   logic signed [31:0] a2_ff;
   logic               status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cd_valid_all;
      end
   end

   // Zero the coefficients of a rejected design; bandpass b2 is -b0
   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= cd_side[0].invalid;
         if (cd_side[0].invalid) begin
            b0_ff <= '0;
            b1_ff <= '0;
            b2_ff <= '0;
            a1_ff <= '0;
            a2_ff <= '0;
         end else begin
            b0_ff <= res[0];
            b1_ff <= res[1];
            b2_ff <= (cd_side[0].cmd == CMD_BANDPASS) ? -res[0] : res[0];
            a1_ff <= res[2];
            a2_ff <= res[3];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coef_b0       = b0_ff;
   assign rsp_coef_b1       = b1_ff;
   assign rsp_coef_b2       = b2_ff;
   assign rsp_coef_a1       = a1_ff;
   assign rsp_coef_a2       = a2_ff;
   assign rsp_design_status = status_ff;

   // ---------------- Assertions
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while result is held");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_design_status) |->
      (rsp_coef_b0 == 32'sd0 && rsp_coef_b1 == 32'sd0 && rsp_coef_b2 == 32'sd0 &&
       rsp_coef_a1 == 32'sd0 && rsp_coef_a2 == 32'sd0))
      else $error("rejected design carries nonzero coefficients");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

[test/tb_biquad_coefficient_designer.sv]
// Self-checking testbench for the biquad coefficient designer.
module tb_biquad_coefficient_designer;
   import bqcd_pkg::*;

   localparam int FRAC_BITS  = 29;
   localparam int ITERATIONS = 24;
   localparam int LATENCY    = 141;
   localparam longint CYCLE_LIMIT = 2000000;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint Q30_TWO_PI  = 64'sd6746518852;
   localparam longint Q30_PI      = 64'sd3373259426;
   localparam longint Q30_HALF_PI = 64'sd1686629713;
   localparam longint Q30_GAIN    = 64'sd652032874;

   typedef struct packed {
      logic signed [31:0] b0;
      logic signed [31:0] b1;
      logic signed [31:0] b2;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      logic               status;
   } coef_set_type;

   typedef struct {
      cmd_type     cmd;
      logic [23:0] cutoff;
      logic [15:0] quality;
      bit          known;
      coef_set_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [23:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = '0;
   logic [23:0]        req_cutoff_hz = '0;
   logic [15:0]        req_quality = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_coef_b0, rsp_coef_b1, rsp_coef_b2, rsp_coef_a1, rsp_coef_a2;
   logic               rsp_design_status;

   logic [23:0]  model_rate = 24'd48000;
   coef_set_type coef_queue[$];
   int           req_idle_pct = 0;
   int           rsp_idle_pct = 0;
   bit           failed = 1'b0;
   longint       cycle_count = 0;

   biquad_coefficient_designer DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_cutoff_hz(req_cutoff_hz), .req_quality(req_quality),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_coef_b0(rsp_coef_b0), .rsp_coef_b1(rsp_coef_b1), .rsp_coef_b2(rsp_coef_b2),
      .rsp_coef_a1(rsp_coef_a1), .rsp_coef_a2(rsp_coef_a2),
      .rsp_design_status(rsp_design_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // End the run on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return (v >= 0) ? (v >> s) : (-64'sd1 - ((-64'sd1 - v) >> s));
   endfunction

   function automatic longint arctan_step(int i);
      longint t[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD};
      if (i < 10) return t[i];
      if (i < 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
   endfunction

   // Rounded, saturated quotient of two Q30 values
   function automatic logic signed [31:0] q30_ratio(longint num, longint den);
      bit neg;
      logic [63:0] mag, q, r, d;
      neg = num < 0;
      mag = neg ? -num : num;
      d = den;
      q = mag / d;
      r = mag % d;
      for (int k = 0; k < FRAC_BITS + 1; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      q = (q + 1) >> 1;
      if (!neg) begin
         if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
         return q[31:0];
      end
      if (q > 64'h80000000) q = 64'h80000000;
      return 32'(-q);
   endfunction

   function automatic coef_set_type design_coefs(cmd_type cmd, logic [23:0] fc,
                                                 logic [15:0] qv);
      coef_set_type res;
      longint w0, x, y, z, dx, dy, alpha, a0, a1n, a2n;
      bit fold;
      logic [63:0] prod;
      res = '0;
      if (model_rate == 0 || fc == 0 || qv == 0 || 25'(2 * 25'(fc)) >= model_rate) begin
         res.status = 1'b1;
         return res;
      end
      prod = 64'(fc) * 64'(Q30_TWO_PI);
      w0 = prod / 64'(model_rate);
      fold = w0 > Q30_HALF_PI;
      z = fold ? Q30_PI - w0 : w0;
      x = Q30_GAIN;
      y = 0;
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      if (fold) x = -x;
      if (y < 0) y = 0;
      alpha = (y * 128) / qv;
      a0 = Q30_ONE + alpha;
      a1n = -2 * x;
      a2n = Q30_ONE - alpha;
      case (cmd)
         CMD_LOWPASS: begin
            res.b0 = q30_ratio(Q30_ONE - x, 2 * a0);
            res.b1 = q30_ratio(Q30_ONE - x, a0);
            res.b2 = res.b0;
         end
         CMD_HIGHPASS: begin
            res.b0 = q30_ratio(Q30_ONE + x, 2 * a0);
            res.b1 = q30_ratio(-(Q30_ONE + x), a0);
            res.b2 = res.b0;
         end
         CMD_BANDPASS: begin
            res.b0 = q30_ratio(alpha, a0);
            res.b1 = 0;
            res.b2 = q30_ratio(-alpha, a0);
         end
         default: begin
            res.b0 = q30_ratio(Q30_ONE, a0);
            res.b1 = q30_ratio(a1n, a0);
            res.b2 = res.b0;
         end
      endcase
      res.a1 = q30_ratio(a1n, a0);
      res.a2 = q30_ratio(a2n, a0);
      return res;
   endfunction

   // Receiver: random stall, compare each transfer with the oldest expectation
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      coef_set_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_coef_b0, rsp_coef_b1, rsp_coef_b2, rsp_coef_a1, rsp_coef_a2,
                 rsp_design_status};
         if (coef_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            failed = 1'b1;
         end else begin
            want = coef_queue.pop_front();
            if (got.b0 !== want.b0) begin
               $display("%0t: b0 expected %0d actual %0d", $time, want.b0, got.b0);
               failed = 1'b1;
            end
            if (got.b1 !== want.b1) begin
               $display("%0t: b1 expected %0d actual %0d", $time, want.b1, got.b1);
               failed = 1'b1;
            end
            if (got.b2 !== want.b2) begin
               $display("%0t: b2 expected %0d actual %0d", $time, want.b2, got.b2);
               failed = 1'b1;
            end
            if (got.a1 !== want.a1) begin
               $display("%0t: a1 expected %0d actual %0d", $time, want.a1, got.a1);
               failed = 1'b1;
            end
            if (got.a2 !== want.a2) begin
               $display("%0t: a2 expected %0d actual %0d", $time, want.a2, got.a2);
               failed = 1'b1;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               failed = 1'b1;
            end
         end
      end
   end

   // Send one design request, idling first at random; hold until the transfer
   task automatic send_design(cmd_type cmd, logic [23:0] fc, logic [15:0] qv,
                              bit known, coef_set_type want);
      coef_set_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_cutoff_hz <= fc;
      req_quality   <= qv;
      do @(posedge clock); while (req_stall);
      pred = design_coefs(cmd, fc, qv);
      if (known && pred !== want) begin
         $display("%0t: table row expected %h actual %h", $time, want, pred);
         failed = 1'b1;
      end
      coef_queue.push_back(pred);
      @(negedge clock);
   endtask

   task automatic drain_and_set_rate(logic [23:0] rate);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (coef_queue.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_rate = rate;
   endtask

   // Pick a request; mostly valid designs below half the rate
   task automatic send_random();
      cmd_type     cmd;
      logic [23:0] fc;
      logic [15:0] qv;
      int          pick;
      cmd  = cmd_type'($urandom_range(3));
      qv   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 32));
      pick = $urandom_range(19);
      if (pick == 0)
         fc = 24'($urandom);
      else if (pick == 1 || model_rate < 3)
         fc = 24'(model_rate >> 1) + 24'($urandom_range(2));
      else
         fc = 24'($urandom_range((model_rate - 1) >> 1, 1));
      send_design(cmd, fc, qv, 1'b0, '0);
   endtask

   stim_row_type rows[$];
   coef_set_type bad;
   logic [23:0]  rates[6];

   initial begin
      bad = '0;
      bad.status = 1'b1;
      // Invalid cases carry a known all-zero result
      rows.push_back('{CMD_LOWPASS,  24'd0,      16'd256,   1'b1, bad});
      rows.push_back('{CMD_HIGHPASS, 24'd1000,   16'd0,     1'b1, bad});
      rows.push_back('{CMD_BANDPASS, 24'd24000,  16'd256,   1'b1, bad});
      rows.push_back('{CMD_NOTCH,    24'hFFFFFF, 16'hFFFF,  1'b1, bad});
      rows.push_back('{CMD_LOWPASS,  24'd23999,  16'd181,   1'b0, '0});
      rows.push_back('{CMD_HIGHPASS, 24'd1,      16'd1,     1'b0, '0});
      rows.push_back('{CMD_BANDPASS, 24'd1,      16'hFFFF,  1'b0, '0});
      rows.push_back('{CMD_NOTCH,    24'd12000,  16'd256,   1'b0, '0});
      rows.push_back('{CMD_LOWPASS,  24'd1000,   16'd181,   1'b0, '0});
      rows.push_back('{CMD_HIGHPASS, 24'd1000,   16'd181,   1'b0, '0});
      rows.push_back('{CMD_BANDPASS, 24'd1000,   16'd181,   1'b0, '0});
      rows.push_back('{CMD_NOTCH,    24'd1000,   16'd181,   1'b0, '0});
      rows.push_back('{CMD_LOWPASS,  24'd20000,  16'd1,     1'b0, '0});
      rows.push_back('{CMD_BANDPASS, 24'd12001,  16'hFFFF,  1'b0, '0});
      rows.push_back('{CMD_NOTCH,    24'd23999,  16'd1,     1'b0, '0});
      rows.push_back('{CMD_HIGHPASS, 24'd12345,  16'h5555,  1'b0, '0});
      rates = '{24'd0, 24'd3, 24'hFFFFFF, 24'd8000, 24'd96000, 24'd44100};

      // Hold reset, then walk the directed table at the reset rate
      @(negedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_design(rows[i].cmd, rows[i].cutoff, rows[i].quality,
                                    rows[i].known, rows[i].want);

      // Random phases across rates and idling patterns
      for (int ph = 0; ph < 18; ph++) begin
         case (ph % 3)
            0: begin req_idle_pct = 23; rsp_idle_pct = 71; end
            1: begin req_idle_pct = 71; rsp_idle_pct = 23; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (ph % 3 == 0) drain_and_set_rate(rates[ph / 3]);
         if (ph == 0) send_design(CMD_LOWPASS, 24'd1, 16'd256, 1'b1, bad);
         repeat (100) send_random();
      end
      drain_and_set_rate(24'($urandom_range(200000, 1)));
      repeat (50) send_random();

      // Wait for the last results, bounded
      req_valid <= 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int w = 0; w < 200000 && coef_queue.size() != 0; w++) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (!failed && coef_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

[files.f]
rtl/bqcd_pkg.sv
rtl/bqcd_div.sv
rtl/bqcd_cordic.sv
rtl/biquad_coefficient_designer.sv
test/tb_biquad_coefficient_designer.sv
